[rtl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion pipeline.
`default_nettype none
package rmq_pkg;

    localparam int ROT_W   = 16;
    localparam int TRANS_W = 32;
    localparam int ARG_W   = 17;
    localparam int MAG_W   = 17;
    localparam int ROOT_W  = 24;
    localparam int SQR_W   = 28;
    localparam int QUO_W   = 23;
    localparam int NUM_W   = 38;
    localparam int FRAC_SH = 21;
    localparam int IN_W    = 9 * ROT_W + 3 * TRANS_W;
    localparam int OUT_W   = 3 * TRANS_W + 4 * ROT_W;
    localparam int PIPE_D  = 2 * ROOT_W + 2;

    localparam logic signed [18:0] ONE_Q14 = 19'sd16384;
    localparam logic [15:0] Q_MAX = 16'h7FFF;
    localparam logic [15:0] Q_MIN = 16'h8000;

    typedef enum logic [1:0] {
        SEL_TRACE,
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

    typedef struct packed {
        logic [3*TRANS_W-1:0]     trans;
        sel_t                     sel;
        logic                     degen;
        logic [2:0]               neg;
        logic [2:0][MAG_W-1:0]    mag;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [15:0] main;
    } tail_t;

endpackage
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// Top level: 3x4 bone transform in, translation plus rotation quaternion out.
`default_nettype none
// Converts a Q1.14 rotation to a Q1.14 quaternion (x, y, z, w) by the
// trace / largest-diagonal method and passes the Q16.16 translation through.
// Fully pipelined: one beat per cycle in and out while the output is not
// stalled; the 24-stage bit-per-stage square root is followed by the
// bit-per-stage dividers. All stages advance together; a stalled output
// holds the whole pipe. A non-positive root argument returns the identity
// quaternion with the tuser flag set.
module rotation_matrix_to_quaternion (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    // trans_x, trans_y, trans_z
    input  wire logic [rmq_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
    output logic [rmq_pkg::OUT_W-1:0]      m_tdata,
    // degenerate
    output logic                           m_tuser
);
    import rmq_pkg::*;

    logic                en;
    logic [PIPE_D-1:0]   vld_reg;
    side_t               f_side;
    logic [ARG_W-1:0]    f_arg;
    logic [ROOT_W-1:0]   root;
    side_t               s_side;
    logic [24:0]         main_sum;
    logic [15:0]         main_q;
    tail_t               tail_reg [ROOT_W];
    logic [QUO_W-1:0]    quo [3];
    logic [15:0]         comp [3];
    logic [15:0]         qx, qy, qz, qw;
    logic [OUT_W-1:0]    data_next;
    logic                degen_q;

    assign en       = !vld_reg[PIPE_D-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_D-2:0], s_tvalid};
        end
    end

    rmq_front u_front (
        .aclk     (aclk),
        .en       (en),
        .in_data  (s_tdata),
        .side_reg (f_side),
        .arg_reg  (f_arg)
    );

    rmq_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .arg      (f_arg),
        .side_in  (f_side),
        .root     (root),
        .side_out (s_side)
    );

    assign main_sum = {1'b0, root} + 25'd256;
    assign main_q   = main_sum[24] ? Q_MAX : (main_sum[23:9] > 15'h7FFF ? Q_MAX
                                              : {1'b0, main_sum[23:9]});

    for (genvar i = 0; i < 3; i++) begin : g_div
        rmq_div u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (s_side.mag[i]),
            .root (root),
            .quo  (quo[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tail_reg[0] <= '{side: s_side, main: main_q};
            for (int i = 1; i < ROOT_W; i++) begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    // saturate each quotient by the sign of its numerator
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (tail_reg[ROOT_W-1].side.neg[i]) begin
                comp[i] = (quo[i] > QUO_W'(Q_MIN)) ? Q_MIN : 16'(-quo[i][15:0]);
            end else begin
                comp[i] = (quo[i] > QUO_W'(Q_MAX)) ? Q_MAX : quo[i][15:0];
            end
        end
    end

    always_comb begin
        degen_q = tail_reg[ROOT_W-1].side.degen;
        unique case (tail_reg[ROOT_W-1].side.sel)
            SEL_TRACE: begin
                qx = comp[0]; qy = comp[1]; qz = comp[2];
                qw = tail_reg[ROOT_W-1].main;
            end
            SEL_X: begin
                qw = comp[0]; qy = comp[1]; qz = comp[2];
                qx = tail_reg[ROOT_W-1].main;
            end
            SEL_Y: begin
                qw = comp[0]; qx = comp[1]; qz = comp[2];
                qy = tail_reg[ROOT_W-1].main;
            end
            default: begin
                qw = comp[0]; qx = comp[1]; qy = comp[2];
                qz = tail_reg[ROOT_W-1].main;
            end
        endcase
        if (degen_q) begin
            qx = '0;
            qy = '0;
            qz = '0;
            qw = 16'd16384;
        end
        data_next = {qw, qz, qy, qx, tail_reg[ROOT_W-1].side.trans};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= data_next;
            m_tuser <= degen_q;
        end
    end

`ifndef SYNTHESIS
    a_degen_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[OUT_W-1 -: 64] == {16'd16384, 48'd0}))
        else $error("degenerate beat without identity quaternion");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with output stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

[rtl/rmq_front.sv]
// Input stage: branch choice, root argument and numerator magnitudes.
`default_nettype none
module rmq_front (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [rmq_pkg::IN_W-1:0] in_data,
    output rmq_pkg::side_t                side_reg,
    output logic [rmq_pkg::ARG_W-1:0]     arg_reg
);
    import rmq_pkg::*;

    logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [17:0] tr;
    logic signed [18:0] arg;
    logic signed [17:0] d [3];
    side_t              side_next;

    assign r00 = in_data[0*ROT_W +: ROT_W];
    assign r01 = in_data[1*ROT_W +: ROT_W];
    assign r02 = in_data[2*ROT_W +: ROT_W];
    assign r10 = in_data[3*ROT_W +: ROT_W];
    assign r11 = in_data[4*ROT_W +: ROT_W];
    assign r12 = in_data[5*ROT_W +: ROT_W];
    assign r20 = in_data[6*ROT_W +: ROT_W];
    assign r21 = in_data[7*ROT_W +: ROT_W];
    assign r22 = in_data[8*ROT_W +: ROT_W];

    assign tr = 18'(r00) + 18'(r11) + 18'(r22);

    always_comb begin
        side_next.trans = in_data[9*ROT_W +: 3*TRANS_W];
        if (tr > 18'sd0) begin
            side_next.sel = SEL_TRACE;
            arg  = ONE_Q14 + 19'(r00) + 19'(r11) + 19'(r22);
            d[0] = 18'(r21) - 18'(r12);
            d[1] = 18'(r02) - 18'(r20);
            d[2] = 18'(r10) - 18'(r01);
        end else if (r00 > r11 && r00 > r22) begin
            side_next.sel = SEL_X;
            arg  = ONE_Q14 + 19'(r00) - 19'(r11) - 19'(r22);
            d[0] = 18'(r21) - 18'(r12);
            d[1] = 18'(r01) + 18'(r10);
            d[2] = 18'(r02) + 18'(r20);
        end else if (r11 > r22) begin
            side_next.sel = SEL_Y;
            arg  = ONE_Q14 + 19'(r11) - 19'(r00) - 19'(r22);
            d[0] = 18'(r02) - 18'(r20);
            d[1] = 18'(r01) + 18'(r10);
            d[2] = 18'(r12) + 18'(r21);
        end else begin
            side_next.sel = SEL_Z;
            arg  = ONE_Q14 + 19'(r22) - 19'(r00) - 19'(r11);
            d[0] = 18'(r10) - 18'(r01);
            d[1] = 18'(r02) + 18'(r20);
            d[2] = 18'(r12) + 18'(r21);
        end
        side_next.degen = arg[18] || (arg == 19'sd0);
        for (int i = 0; i < 3; i++) begin
            side_next.neg[i] = d[i][17];
            side_next.mag[i] = d[i][17] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            arg_reg  <= arg[ARG_W-1:0];
        end
    end

endmodule
`default_nettype wire

[rtl/rmq_sqrt.sv]
// Integer square root of arg * 2^30, one root bit per pipeline stage.
`default_nettype none
module rmq_sqrt (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [rmq_pkg::ARG_W-1:0] arg,
    input  rmq_pkg::side_t                 side_in,
    output logic [rmq_pkg::ROOT_W-1:0]     root,
    output rmq_pkg::side_t                 side_out
);
    import rmq_pkg::*;

    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    logic [SQR_W-1:0]  rem_reg  [ROOT_W+1];
    logic [ARG_W-1:0]  arg_reg  [ROOT_W+1];
    side_t             side_reg [ROOT_W+1];

    assign root_reg[0] = '0;
    assign rem_reg[0]  = '0;
    assign arg_reg[0]  = arg;
    assign side_reg[0] = side_in;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic [2*ROOT_W-1:0] v;
        logic [SQR_W-1:0]    rem_sh;
        logic [SQR_W-1:0]    trial;
        logic [SQR_W-1:0]    rem_next;
        logic [ROOT_W-1:0]   root_next;

        assign v      = {(2*ROOT_W-ARG_W-30)'(0), arg_reg[s], 30'd0};
        assign rem_sh = {rem_reg[s][SQR_W-3:0], v[2*B+1 -: 2]};
        assign trial  = SQR_W'({root_reg[s], 2'b01});

        always_comb begin
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[s][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[s][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[s+1] <= root_next;
                rem_reg[s+1]  <= rem_next;
                arg_reg[s+1]  <= arg_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign root     = root_reg[ROOT_W];
    assign side_out = side_reg[ROOT_W];

endmodule
`default_nettype wire

[rtl/rmq_div.sv]
// Rounded quotient (mag * 2^21 + root/2) / root, one quotient bit per stage.
`default_nettype none
module rmq_div (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [rmq_pkg::MAG_W-1:0]  mag,
    input  wire logic [rmq_pkg::ROOT_W-1:0] root,
    output logic [rmq_pkg::QUO_W-1:0]       quo
);
    import rmq_pkg::*;

    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] rr_reg  [QUO_W+1];
    logic [QUO_W-1:0]  lo_reg  [QUO_W+1];
    logic [QUO_W-1:0]  q_reg   [QUO_W+1];
    logic [ROOT_W-1:0] dv_reg  [QUO_W+1];

    assign num = {mag, FRAC_SH'(0)} + NUM_W'(root[ROOT_W-1:1]);

    // numerator head is below the divisor since the quotient fits QUO_W bits
    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg[0] <= ROOT_W'(num[NUM_W-1:QUO_W]);
            lo_reg[0] <= num[QUO_W-1:0];
            q_reg[0]  <= '0;
            dv_reg[0] <= root;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic [ROOT_W:0]   sh;
        logic [ROOT_W:0]   diff;
        logic              take;

        assign sh   = {rr_reg[j], lo_reg[j][QUO_W-1-j]};
        assign diff = sh - {1'b0, dv_reg[j]};
        assign take = (sh >= {1'b0, dv_reg[j]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rr_reg[j+1] <= take ? diff[ROOT_W-1:0] : sh[ROOT_W-1:0];
                q_reg[j+1]  <= {q_reg[j][QUO_W-2:0], take};
                lo_reg[j+1] <= lo_reg[j];
                dv_reg[j+1] <= dv_reg[j];
            end
        end
    end

    assign quo = q_reg[QUO_W];

endmodule
`default_nettype wire
